[src/cmps_pkg.sv]
// ----------------------------------------------------------------------------
// Collinear marker pair search package
// Shared constants, register codes, controller commands and status types.
// ----------------------------------------------------------------------------
package cmps_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_INNER  = 7;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int INNER_W    = 3;
    localparam int COORD_W    = 16;
    localparam int ADDR_W     = 4;

    localparam logic [ADDR_W-1:0] REG_MIN_DISTANCE = 4'h0;
    localparam logic [ADDR_W-1:0] REG_MAX_DISTANCE = 4'h4;
    localparam logic [ADDR_W-1:0] REG_INNER_COUNT  = 4'h8;
    localparam logic [ADDR_W-1:0] REG_NEAR_RADIUS  = 4'hC;

    localparam logic [15:0] RST_MIN_DISTANCE = 16'd1440;
    localparam logic [15:0] RST_MAX_DISTANCE = 16'd1600;
    localparam logic [2:0]  RST_INNER_COUNT  = 3'd2;
    localparam logic [15:0] RST_NEAR_RADIUS  = 16'd80;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic [COORD_W-1:0] min_distance;
        logic [COORD_W-1:0] max_distance;
        logic [INNER_W-1:0] inner_count;
        logic [COORD_W-1:0] near_radius;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             lat_a;
        logic             lat_b;
        logic             pair_eval;
        logic             step_calc;
        logic             pos_calc;
        logic             cand_eval;
        logic             res_hit;
        logic             res_miss;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pair_in_range;
        logic near_hit;
        logic div_busy;
    } t_sts;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [5:0]         first_index;
        logic [5:0]         second_index;
    } t_result;

endpackage

[src/cmps_point_if.sv]
// ----------------------------------------------------------------------------
// Point channel interface
// Valid and ready handshake carrying one centroid per transfer.
// ----------------------------------------------------------------------------
interface cmps_point_if;
    logic        valid;
    logic        ready;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        is_final;

    modport source (output valid, output point_x, output point_y, output is_final,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input is_final,
                    output ready);
endinterface

[src/cmps_result_if.sv]
// ----------------------------------------------------------------------------
// Result channel interface
// Valid and ready handshake carrying one search result per transfer.
// ----------------------------------------------------------------------------
interface cmps_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [5:0]  first_index;
    logic [5:0]  second_index;

    modport source (output valid, output found, output center_x, output center_y,
                    output first_index, output second_index, input ready);
    modport sink   (input valid, input found, input center_x, input center_y,
                    input first_index, input second_index, output ready);
endinterface

[src/cmps_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cmps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/cmps_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for distance limits, inner count and radius.
// ----------------------------------------------------------------------------
module cmps_regs
    import cmps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_distance <= RST_MIN_DISTANCE;
            r_cfg.max_distance <= RST_MAX_DISTANCE;
            r_cfg.inner_count  <= RST_INNER_COUNT;
            r_cfg.near_radius  <= RST_NEAR_RADIUS;
        end else if (w_wr) begin
            case (paddr)
                REG_MIN_DISTANCE: r_cfg.min_distance <= pwdata[15:0];
                REG_MAX_DISTANCE: r_cfg.max_distance <= pwdata[15:0];
                REG_INNER_COUNT:  r_cfg.inner_count  <= pwdata[2:0];
                REG_NEAR_RADIUS:  r_cfg.near_radius  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            REG_MIN_DISTANCE: prdata = {16'd0, r_cfg.min_distance};
            REG_MAX_DISTANCE: prdata = {16'd0, r_cfg.max_distance};
            REG_INNER_COUNT:  prdata = {29'd0, r_cfg.inner_count};
            REG_NEAR_RADIUS:  prdata = {16'd0, r_cfg.near_radius};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

[src/cmps_datapath.sv]
// ----------------------------------------------------------------------------
// Search datapath
// Point store, squared distance units, step divider and result register.
// ----------------------------------------------------------------------------
module cmps_datapath
    import cmps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_point           i_wr_point,
    input  t_cmd             i_cmd,
    input  logic [IDX_W-1:0] i_idx_a,
    input  logic [IDX_W-1:0] i_idx_b,
    input  logic [3:0]       i_k,
    output t_sts             o_sts,
    output t_result          o_result
);
    t_point w_rd;
    logic [31:0] w_rdata;

    cmps_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_wr_en),
        .i_waddr(i_wr_addr),
        .i_wdata({i_wr_point.y, i_wr_point.x}),
        .i_re   (i_cmd.rd_en),
        .i_raddr(i_cmd.rd_addr),
        .o_rdata(w_rdata)
    );
    assign w_rd.x = w_rdata[15:0];
    assign w_rd.y = w_rdata[31:16];

    t_point r_a, r_b;
    logic [32:0] w_dx2, w_dy2;
    logic [33:0] w_d2;
    logic [31:0] r_lo2, r_hi2, r_r2;

    // Squared register limits; user keeps them stable in a search, unchecked.
    always_ff @(posedge i_clk) begin
        r_lo2 <= i_cfg.min_distance * i_cfg.min_distance;
        r_hi2 <= i_cfg.max_distance * i_cfg.max_distance;
        r_r2  <= i_cfg.near_radius * i_cfg.near_radius;
    end

    logic signed [17:0] r_px, r_py;
    logic signed [16:0] w_ex, w_ey;
    logic signed [18:0] w_cx, w_cy;
    logic signed [17:0] w_sx, w_sy;

    assign w_ex = i_cmd.pair_eval ? $signed({1'b0, r_b.x}) - $signed({1'b0, r_a.x})
                                  : 17'sd0;
    assign w_ey = i_cmd.pair_eval ? $signed({1'b0, r_b.y}) - $signed({1'b0, r_a.y})
                                  : 17'sd0;
    assign w_cx = i_cmd.cand_eval ? 19'(r_px) - $signed({3'b0, w_rd.x}) : 19'sd0;
    assign w_cy = i_cmd.cand_eval ? 19'(r_py) - $signed({3'b0, w_rd.y}) : 19'sd0;

    // One shared squaring pair for both pair distance and candidate distance.
    logic signed [18:0] w_mx, w_my;
    logic [35:0] r_cx2, r_cy2;
    logic r_pair_v, r_cand_v;
    assign w_mx = i_cmd.pair_eval ? 19'(w_ex) : w_cx;
    assign w_my = i_cmd.pair_eval ? 19'(w_ey) : w_cy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_a) r_a <= w_rd;
        if (i_cmd.lat_b) r_b <= w_rd;
        r_cx2 <= 36'(w_mx * w_mx);
        r_cy2 <= 36'(w_my * w_my);
        if (!i_rst_n) begin
            r_pair_v <= 1'b0;
            r_cand_v <= 1'b0;
        end else begin
            r_pair_v <= i_cmd.pair_eval;
            r_cand_v <= i_cmd.cand_eval;
        end
    end
    assign w_dx2 = r_cx2[32:0];
    assign w_dy2 = r_cy2[32:0];
    assign w_d2  = {1'b0, w_dx2} + {1'b0, w_dy2};

    logic r_in_range, r_near;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.lat_a || i_cmd.lat_b || i_cmd.pos_calc) begin
            r_in_range <= 1'b0;
            r_near     <= 1'b0;
        end else begin
            if (r_pair_v) begin
                r_in_range <= ({2'b0, r_lo2} < w_d2) && (w_d2 < {2'b0, r_hi2});
            end
            if (r_cand_v && (w_d2 <= {2'b0, r_r2})) begin
                r_near <= 1'b1;
            end
        end
    end

    // Restoring divider: signed span magnitude by (n + 1), one bit per cycle.
    logic [4:0]  r_div_cnt;
    logic [16:0] r_qx, r_qy, r_rx, r_ry;
    logic        r_negx, r_negy;
    logic [3:0]  w_den;
    logic [16:0] w_trx, w_try;
    logic [2:0]  w_n;

    assign w_n   = i_cfg.inner_count;
    assign w_den = {1'b0, w_n} + 4'd1;
    assign w_trx = {r_rx[15:0], r_qx[16]};
    assign w_try = {r_ry[15:0], r_qy[16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= 5'd0;
        end else if (i_cmd.step_calc) begin
            r_div_cnt <= 5'd17;
            r_negx    <= r_b.x < r_a.x;
            r_negy    <= r_b.y < r_a.y;
            r_qx      <= (r_b.x < r_a.x) ? 17'(r_a.x - r_b.x) : 17'(r_b.x - r_a.x);
            r_qy      <= (r_b.y < r_a.y) ? 17'(r_a.y - r_b.y) : 17'(r_b.y - r_a.y);
            r_rx      <= 17'd0;
            r_ry      <= 17'd0;
        end else if (r_div_cnt != 5'd0) begin
            r_div_cnt <= r_div_cnt - 5'd1;
            if (w_trx >= {13'd0, w_den}) begin
                r_rx <= w_trx - {13'd0, w_den};
                r_qx <= {r_qx[15:0], 1'b1};
            end else begin
                r_rx <= w_trx;
                r_qx <= {r_qx[15:0], 1'b0};
            end
            if (w_try >= {13'd0, w_den}) begin
                r_ry <= w_try - {13'd0, w_den};
                r_qy <= {r_qy[15:0], 1'b1};
            end else begin
                r_ry <= w_try;
                r_qy <= {r_qy[15:0], 1'b0};
            end
        end
    end

    always_comb begin
        w_sx = r_negx ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
        w_sy = r_negy ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});
    end

    // Inner position a + k * step; stays within 0..65535 by construction.
    logic signed [22:0] w_kx, w_ky;
    assign w_kx = $signed({1'b0, i_k}) * w_sx;
    assign w_ky = $signed({1'b0, i_k}) * w_sy;
    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_calc) begin
            r_px <= 18'($signed({1'b0, r_a.x}) + w_kx);
            r_py <= 18'($signed({1'b0, r_a.y}) + w_ky);
        end
    end

    t_result r_res;
    logic [16:0] w_sumx, w_sumy;
    assign w_sumx = {1'b0, r_a.x} + {1'b0, r_b.x};
    assign w_sumy = {1'b0, r_a.y} + {1'b0, r_b.y};
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_hit) begin
            r_res.found        <= 1'b1;
            r_res.center_x     <= w_sumx[16:1];
            r_res.center_y     <= w_sumy[16:1];
            r_res.first_index  <= 6'(i_idx_a);
            r_res.second_index <= 6'(i_idx_b);
        end else if (i_cmd.res_miss) begin
            r_res <= '0;
        end
    end

    assign o_result           = r_res;
    assign o_sts.pair_in_range = r_in_range;
    assign o_sts.near_hit      = r_near;
    assign o_sts.div_busy      = r_div_cnt != 5'd0;
endmodule

[src/cmps_ctrl.sv]
// ----------------------------------------------------------------------------
// Search controller
// Loads points, walks pairs and inner positions, and hands off the result.
// ----------------------------------------------------------------------------
module cmps_ctrl
    import cmps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    input  logic             i_in_final,
    output logic             o_in_ready,
    output logic             o_wr_en,
    output logic [IDX_W-1:0] o_wr_addr,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_idx_a,
    output logic [IDX_W-1:0] o_idx_b,
    output logic [3:0]       o_k,
    input  t_sts             i_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready
);
    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_RD_A   = 4'd1;
    localparam logic [3:0] S_RD_B   = 4'd2;
    localparam logic [3:0] S_LAT_B  = 4'd3;
    localparam logic [3:0] S_PAIR   = 4'd4;
    localparam logic [3:0] S_PCHK   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_POS    = 4'd7;
    localparam logic [3:0] S_CRD    = 4'd8;
    localparam logic [3:0] S_CAND   = 4'd9;
    localparam logic [3:0] S_CEND   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;
    localparam logic [3:0] S_LAT_A  = 4'd12;
    localparam logic [3:0] S_DRAIN  = 4'd13;
    localparam logic [3:0] S_CWAIT  = 4'd14;
    localparam logic [3:0] S_CCHK   = 4'd15;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_a, n_a, r_b, n_b, r_c, n_c;
    logic [3:0]       r_k, n_k;
    logic             r_found, n_found;
    logic [3:0]       w_n;
    logic [CNT_W-1:0] w_last;

    assign w_n    = {1'b0, i_cfg.inner_count};
    assign w_last = r_count - CNT_W'(1);

    assign o_in_ready = (r_state == S_LOAD);
    assign o_wr_en    = o_in_ready && i_in_valid && (r_count < CNT_W'(MAX_POINTS));
    assign o_wr_addr  = r_count[IDX_W-1:0];
    assign o_idx_a    = r_a;
    assign o_idx_b    = r_b;
    assign o_k        = r_k;
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_k     = r_k;
        n_found = r_found;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (o_wr_en) n_count = r_count + CNT_W'(1);
                    if (i_in_final) begin
                        n_a     = '0;
                        n_found = 1'b0;
                        if (CNT_W'(o_wr_en) + r_count >= CNT_W'(w_n) + CNT_W'(2)) begin
                            n_state = S_RD_A;
                        end else begin
                            n_state = S_CEND;
                        end
                    end
                end
            end
            S_RD_A: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_a;
                n_b     = r_a + IDX_W'(1);
                n_state = S_LAT_A;
            end
            S_LAT_A: begin
                o_cmd.lat_a = 1'b1;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_b;
                n_state = S_LAT_B;
            end
            S_LAT_B: begin
                o_cmd.lat_b = 1'b1;
                n_state = S_PAIR;
            end
            S_PAIR: begin
                o_cmd.pair_eval = 1'b1;
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (i_sts.pair_in_range) begin
                    o_cmd.step_calc = 1'b1;
                    n_k     = 4'd1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_CEND;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    if (r_k > w_n) begin
                        n_found = 1'b1;
                        n_state = S_CEND;
                    end else begin
                        n_state = S_POS;
                    end
                end
            end
            S_POS: begin
                o_cmd.pos_calc = 1'b1;
                n_c     = '0;
                n_state = S_CRD;
            end
            S_CRD: begin
                // Issue reads across the store; each read is evaluated in S_CAND.
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_c;
                n_state = S_CAND;
            end
            S_CAND: begin
                o_cmd.cand_eval = 1'b1;
                if (CNT_W'(r_c) == w_last) begin
                    n_state = S_CWAIT;
                end else begin
                    n_c     = r_c + IDX_W'(1);
                    n_state = S_CRD;
                end
            end
            S_CWAIT: begin
                n_state = S_CCHK;
            end
            S_CCHK: begin
                if (i_sts.near_hit) begin
                    n_k     = r_k + 4'd1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                if (r_found) begin
                    o_cmd.res_hit = 1'b1;
                    n_state = S_OUT;
                end else if (r_count >= CNT_W'(w_n) + CNT_W'(2) &&
                             CNT_W'(r_b) < w_last) begin
                    n_b     = r_b + IDX_W'(1);
                    n_state = S_RD_B;
                end else if (r_count >= CNT_W'(w_n) + CNT_W'(2) &&
                             CNT_W'(r_a) + CNT_W'(2) < r_count) begin
                    n_a     = r_a + IDX_W'(1);
                    n_state = S_RD_A;
                end else begin
                    o_cmd.res_miss = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_count = '0;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_k <= n_k;
    end

`ifndef ASSERT_OFF
    a_no_input_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !o_in_ready)
        else $error("input taken during search");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count overflow");
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAIR) |-> (r_b > r_a))
        else $error("pair indices out of order");
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (r_count == '0))
        else $error("store not emptied after result");
`endif
endmodule

[src/collinear_marker_pair_search_unit.sv]
// ----------------------------------------------------------------------------
// Collinear marker pair search unit
// Stores centroids and searches for a collinear marker pair on the last one.
// ----------------------------------------------------------------------------
// Points load at one per cycle. On the final point the input stalls while the
// pairs are walked in order: each pair is read and its distance tested, a
// passing distance test adds a step division, and each inner position scans
// the whole store through the single read port. One result is offered per
// final point and the store is emptied once it is taken.
module collinear_marker_pair_search_unit
    import cmps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    cmps_point_if.sink        i_point,
    cmps_result_if.source     o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    t_cfg             w_cfg;
    t_cmd             w_cmd;
    t_sts             w_sts;
    t_result          w_res;
    t_point           w_pt;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr, w_a, w_b;
    logic [3:0]       w_k;

    cmps_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(w_cfg)
    );

    assign w_pt.x = i_point.point_x;
    assign w_pt.y = i_point.point_y;

    cmps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_cfg),
        .i_in_valid(i_point.valid), .i_in_final(i_point.is_final),
        .o_in_ready(i_point.ready), .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr),
        .o_cmd(w_cmd), .o_idx_a(w_a), .o_idx_b(w_b), .o_k(w_k), .i_sts(w_sts),
        .o_out_valid(o_result.valid), .i_out_ready(o_result.ready)
    );

    cmps_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_cfg), .i_wr_en(w_wr_en),
        .i_wr_addr(w_wr_addr), .i_wr_point(w_pt), .i_cmd(w_cmd), .i_idx_a(w_a),
        .i_idx_b(w_b), .i_k(w_k), .o_sts(w_sts), .o_result(w_res)
    );

    assign o_result.found        = w_res.found;
    assign o_result.center_x     = w_res.center_x;
    assign o_result.center_y     = w_res.center_y;
    assign o_result.first_index  = w_res.first_index;
    assign o_result.second_index = w_res.second_index;
endmodule

[sim/collinear_marker_pair_search_unit_tb.sv]
// ----------------------------------------------------------------------------
// Collinear marker pair search unit testbench
// Drives point sets through the point channel, predicts each search result
// with a behavioral search over the stored set, and compares every result
// transfer field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module collinear_marker_pair_search_unit_tb;
    import cmps_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        fin;
        logic        has_exp;
        t_result     exp_res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cmps_point_if  pt_ch();
    cmps_result_if res_ch();

    collinear_marker_pair_search_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (pt_ch.sink),
        .o_result (res_ch.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic [15:0] cfg_min_dist;
    logic [15:0] cfg_max_dist;
    logic [2:0]  cfg_inner;
    logic [15:0] cfg_radius;
    logic [31:0] set_points[MAX_POINTS];
    int          set_count;
    t_result     pending_results[$];
    int          error_count;
    int          idle_cycles;
    logic        hold_off_req;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] dist_sq(longint ax, longint ay, longint bx, longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return 64'(dx * dx) + 64'(dy * dy);
    endfunction

    function automatic logic marker_present(longint px, longint py);
        logic [63:0] r2;
        r2 = 64'(cfg_radius) * 64'(cfg_radius);
        for (int i = 0; i < set_count; i++) begin
            if (dist_sq(px, py, set_points[i][15:0], set_points[i][31:16]) <= r2) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic pair_qualifies(int a, int b);
        longint ax;
        longint ay;
        longint bx;
        longint by;
        longint sx;
        longint sy;
        logic [63:0] d2;
        int n;
        n  = cfg_inner;
        ax = set_points[a][15:0];
        ay = set_points[a][31:16];
        bx = set_points[b][15:0];
        by = set_points[b][31:16];
        d2 = dist_sq(ax, ay, bx, by);
        if (!(64'(cfg_min_dist) * cfg_min_dist < d2 && d2 < 64'(cfg_max_dist) * cfg_max_dist)) begin
            return 1'b0;
        end
        sx = (bx - ax) / (n + 1);
        sy = (by - ay) / (n + 1);
        for (int k = 1; k <= n; k++) begin
            if (!marker_present(ax + k * sx, ay + k * sy)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Stores one accepted point and returns the search outcome on a final one.
    function automatic logic store_point(logic [15:0] x, logic [15:0] y, logic fin,
                                         output t_result res);
        longint s;
        res = '0;
        if (set_count < MAX_POINTS) begin
            set_points[set_count] = {y, x};
            set_count++;
        end
        if (!fin) begin
            return 1'b0;
        end
        if (set_count >= cfg_inner + 2) begin
            for (int a = 0; a + 1 < set_count && !res.found; a++) begin
                for (int b = a + 1; b < set_count; b++) begin
                    if (pair_qualifies(a, b)) begin
                        res.found = 1'b1;
                        s = longint'(set_points[a][15:0]) + set_points[b][15:0];
                        res.center_x = 16'(s / 2);
                        s = longint'(set_points[a][31:16]) + set_points[b][31:16];
                        res.center_y = 16'(s / 2);
                        res.first_index  = 6'(a);
                        res.second_index = 6'(b);
                        break;
                    end
                end
            end
        end
        set_count = 0;
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_MIN_DISTANCE: cfg_min_dist = data[15:0];
            REG_MAX_DISTANCE: cfg_max_dist = data[15:0];
            REG_INNER_COUNT:  cfg_inner    = data[2:0];
            REG_NEAR_RADIUS:  cfg_radius   = data[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [2:0] inner, input logic [15:0] rad);
        wait_drained();
        write_reg(REG_MIN_DISTANCE, {16'h0, lo});
        write_reg(REG_MAX_DISTANCE, {16'h0, hi});
        write_reg(REG_INNER_COUNT, {29'h0, inner});
        write_reg(REG_NEAR_RADIUS, {16'h0, rad});
    endtask

    // Offers one point and returns once it has been accepted.
    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic fin,
                              input logic has_exp, input t_result exp_res);
        t_result res;
        pt_ch.valid    <= 1'b1;
        pt_ch.point_x  <= x;
        pt_ch.point_y  <= y;
        pt_ch.is_final <= fin;
        @(posedge i_clk);
        while (!pt_ch.ready) @(posedge i_clk);
        if (store_point(x, y, fin, res)) begin
            if (has_exp && res !== exp_res) begin
                $display("%0t: directed row disagrees with predictor: %p vs %p",
                         $time, exp_res, res);
                error_count++;
            end
            pending_results.push_back(res);
        end
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0) begin
            pt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic end_burst();
        pt_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // A marker set: a pair often at distance inside the limits with inner points
    // at the evenly spaced positions, jittered by up to 3 per axis, plus clutter.
    task automatic send_marker_set(input int size_cap);
        int n;
        int total;
        int pos;
        int inner_at;
        longint ax;
        longint ay;
        longint dx;
        longint dy;
        longint d;
        logic [15:0] px[$];
        logic [15:0] py[$];
        n     = cfg_inner;
        total = $urandom_range(n + 2, size_cap);
        d     = (longint'(cfg_min_dist) + cfg_max_dist) / 2;
        dx    = $urandom_range(0, 1) ? d : (d * 3) / 5;
        dy    = $urandom_range(0, 1) ? 0 : (d * 4) / 5;
        if (dy == 0) dx = d;
        if ($urandom_range(0, 1)) dx = -dx;
        ax = $urandom_range(4000, 60000);
        ay = $urandom_range(4000, 60000);
        for (int i = 0; i < total; i++) begin
            px.push_back(16'($urandom));
            py.push_back(16'($urandom));
        end
        pos = $urandom_range(0, total - n - 2);
        px[pos] = 16'(ax);
        py[pos] = 16'(ay);
        px[total - 1 - $urandom_range(0, 0)] = 16'(ax + dx);
        py[total - 1] = 16'(ay + dy);
        for (int k = 1; k <= n; k++) begin
            inner_at = pos + k;
            px[inner_at] = 16'(ax + k * (dx / (n + 1)) + $signed($urandom_range(0, 6)) - 3);
            py[inner_at] = 16'(ay + k * (dy / (n + 1)) + $signed($urandom_range(0, 6)) - 3);
        end
        for (int i = 0; i < total; i++) begin
            send_point(px[i], py[i], i == total - 1, 1'b0, '0);
            if (i != total - 1) sender_gap();
        end
        if ($urandom_range(0, 2) == 0) end_burst();
    endtask

    task automatic send_noise_set(input int size_cap);
        int total;
        total = $urandom_range(1, size_cap);
        for (int i = 0; i < total; i++) begin
            send_point(16'($urandom), 16'($urandom), i == total - 1, 1'b0, '0);
            sender_gap();
        end
    endtask

    // Result side: stall pattern, long hold-off on request, and checking.
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            res_ch.ready <= ($urandom_range(0, 7) < 5) || (($time / 20000) % 4 == 0);
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, actual found=%0b", $time,
                         res_ch.found);
                error_count++;
            end else begin
                t_result exp_r;
                exp_r = pending_results.pop_front();
                if (res_ch.found !== exp_r.found ||
                    res_ch.center_x !== exp_r.center_x ||
                    res_ch.center_y !== exp_r.center_y ||
                    res_ch.first_index !== exp_r.first_index ||
                    res_ch.second_index !== exp_r.second_index) begin
                    $display("%0t: result mismatch expected %0b %0d %0d %0d %0d actual %0b %0d %0d %0d %0d",
                             $time, exp_r.found, exp_r.center_x, exp_r.center_y,
                             exp_r.first_index, exp_r.second_index, res_ch.found,
                             res_ch.center_x, res_ch.center_y, res_ch.first_index,
                             res_ch.second_index);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("collinear_marker_pair_search_unit_tb: FAIL");
            $finish;
        end
    end

    t_stim_row directed[$];

    initial begin
        t_result hit;
        int      items;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        pt_ch.valid    <= 1'b0;
        pt_ch.point_x  <= '0;
        pt_ch.point_y  <= '0;
        pt_ch.is_final <= 1'b0;
        error_count    = 0;
        idle_cycles    = 0;
        hold_off_req   = 1'b0;
        set_count      = 0;
        cfg_min_dist   = RST_MIN_DISTANCE;
        cfg_max_dist   = RST_MAX_DISTANCE;
        cfg_inner      = RST_INNER_COUNT;
        cfg_radius     = RST_NEAR_RADIUS;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a lone final point, extremes, then a passing horizontal
        // pair at distance 1500 with two exact inner markers, then a short set.
        hit = '{found: 1'b1, center_x: 16'd1750, center_y: 16'd1000,
                first_index: 6'd0, second_index: 6'd3};
        directed = '{
            '{16'h0000, 16'h0000, 1'b1, 1'b1, t_result'('0)},
            '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, t_result'('0)},
            '{16'h0000, 16'hFFFF, 1'b0, 1'b0, t_result'('0)},
            '{16'hFFFF, 16'h0000, 1'b1, 1'b1, t_result'('0)},
            '{16'd1000, 16'd1000, 1'b0, 1'b0, t_result'('0)},
            '{16'd1500, 16'd1000, 1'b0, 1'b0, t_result'('0)},
            '{16'd2000, 16'd1000, 1'b0, 1'b0, t_result'('0)},
            '{16'd2500, 16'd1000, 1'b1, 1'b1, hit},
            '{16'd1000, 16'd1000, 1'b0, 1'b0, t_result'('0)},
            '{16'd2600, 16'd1000, 1'b1, 1'b1, t_result'('0)}
        };
        foreach (directed[i]) begin
            send_point(directed[i].x, directed[i].y, directed[i].fin,
                       directed[i].has_exp, directed[i].exp_res);
        end
        end_burst();

        // Zero inner count, zero radius, widest limits; then the store-full case.
        set_config(16'd0, 16'hFFFF, 3'd0, 16'd0);
        send_point(16'd5, 16'd5, 1'b0, 1'b0, '0);
        send_point(16'd5, 16'd5, 1'b1, 1'b1, '0);
        send_point(16'd0, 16'd0, 1'b0, 1'b0, '0);
        send_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0);
        for (int i = 0; i < MAX_POINTS + 2; i++) begin
            send_point(16'd100, 16'd100, i == MAX_POINTS + 1, 1'b0, '0);
        end
        end_burst();
        set_config(16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF);
        send_noise_set(9);
        end_burst();

        // Random part: a sweep of settings, mostly well-formed sets.
        items = 0;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_config(16'd1440, 16'd1600, 3'd2, 16'd80);
                1: set_config(16'd200, 16'd900, 3'd1, 16'd16);
                2: set_config(16'd3000, 16'd3400, 3'd7, 16'd40);
                3: set_config(16'd50, 16'd400, 3'd0, 16'd0);
                4: set_config(16'($urandom_range(100, 2000)), 16'($urandom_range(2100, 9000)),
                              3'($urandom_range(0, 7)), 16'($urandom_range(0, 300)));
                5: set_config(16'd0, 16'd60000, 3'd3, 16'd5);
                6: set_config(16'd1000, 16'd1500, 3'd4, 16'hFFFF);
                default: set_config(16'd500, 16'd2500, 3'd2, 16'd30);
            endcase
            if (phase == 2) hold_off_req = 1'b1;
            while (items < (phase + 1) * 125) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_marker_set(phase == 2 ? 12 : 16);
                end else begin
                    send_noise_set(10);
                end
                items = items + 8;
                if (phase == 5 && items % 40 < 8) begin
                    end_burst();
                    wait_drained();
                end
            end
            end_burst();
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("collinear_marker_pair_search_unit_tb: PASS");
        end else begin
            $display("collinear_marker_pair_search_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
